// ----- rtl/core/mwdh_pkg.sv -----
// shared types and constants for the mass weighted density histogram unit
// bin store geometry, command queue entry, op codes, config register map
// no dependencies
`default_nettype none

package mwdh_pkg;

    localparam int BIN_DEPTH   = 512;
    localparam int BIN_IDX_W   = $clog2(BIN_DEPTH);
    localparam int SEL_W       = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = 96;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_UP_BOUND   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BINS       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE = CFG_IDX_W'(4);

    localparam logic [31:0] RST_LOW_BOUND  = 32'd0;
    localparam logic [31:0] RST_UP_BOUND   = 32'd786432;
    localparam logic [31:0] RST_INV_WIDTH  = 32'd1638400;
    localparam logic [9:0]  RST_BINS       = 10'd300;
    localparam logic [31:0] RST_NORM_SCALE = 32'd65536;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FRAME = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [31:0] low_bound;
        logic signed [31:0] up_bound;
        logic [31:0]        inv_width;
        logic [9:0]         bins_in_use;
        logic [31:0]        norm_scale;
    } cfg_t;

    typedef struct packed {
        op_t                  op;
        logic [BIN_IDX_W-1:0] idx;
        logic                 sel_ok;
        logic [SEL_W-1:0]     sel;
        logic [31:0]          mass;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/mwdh_front.sv -----
// front end: takes requests, bounds check, bin index by multiply, clamp
// two elastic stages feeding the command queue
// depends on mwdh_pkg
`default_nettype none

module mwdh_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mwdh_pkg::cfg_t        cfg,
    input  wire logic                  hold,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            op,
    input  wire logic signed [31:0]    position,
    input  wire logic [31:0]           mass,
    input  wire logic [mwdh_pkg::SEL_W-1:0] bin_select,
    output logic                       q_push,
    output mwdh_pkg::cmd_t             q_cmd,
    input  wire logic                  q_full
);

    logic                          s1_valid_reg;
    mwdh_pkg::op_t                 s1_op_reg;
    logic [31:0]                   s1_diff_reg;
    logic                          s1_in_range_reg;
    logic [31:0]                   s1_mass_reg;
    logic [mwdh_pkg::SEL_W-1:0]    s1_sel_reg;
    logic                          s1_sel_ok_reg;

    logic                          s2_valid_reg;
    mwdh_pkg::op_t                 s2_op_reg;
    logic [31:0]                   s2_bin_reg;
    logic [31:0]                   s2_mass_reg;
    logic [mwdh_pkg::SEL_W-1:0]    s2_sel_reg;
    logic                          s2_sel_ok_reg;

    logic        accept;
    logic        s1_move;
    logic        s2_free;
    logic        in_range;
    logic [32:0] diff_wide;
    logic [63:0] prod;
    logic [31:0] eff_bins;
    logic [31:0] last_bin;
    logic [31:0] bin_clamped;

    assign q_push  = s2_valid_reg && !q_full;
    assign s2_free = !s2_valid_reg || q_push;
    assign s1_move = s1_valid_reg && s2_free;
    assign full    = (s1_valid_reg && !s1_move) || hold;
    assign accept  = push && !full;

    assign in_range  = ($signed(position) > $signed(cfg.low_bound))
                    && ($signed(position) < $signed(cfg.up_bound));
    assign diff_wide = {position[31], position} - {cfg.low_bound[31], cfg.low_bound};
    assign prod      = 64'(s1_diff_reg) * 64'(cfg.inv_width);

    // bins in use limited to one .. store depth
    always_comb
    begin
        eff_bins = 32'(cfg.bins_in_use);
        if (eff_bins == 32'd0)
        begin
            eff_bins = 32'd1;
        end
        if (eff_bins > 32'(mwdh_pkg::BIN_DEPTH))
        begin
            eff_bins = 32'(mwdh_pkg::BIN_DEPTH);
        end
        last_bin    = eff_bins - 32'd1;
        bin_clamped = (s2_bin_reg > last_bin) ? last_bin : s2_bin_reg;
    end

    always_comb
    begin
        q_cmd.op     = s2_op_reg;
        q_cmd.mass   = s2_mass_reg;
        q_cmd.sel    = s2_sel_reg;
        q_cmd.sel_ok = s2_sel_ok_reg;
        if (s2_op_reg == mwdh_pkg::OP_READ)
        begin
            q_cmd.idx = mwdh_pkg::BIN_IDX_W'(s2_sel_reg);
        end
        else
        begin
            q_cmd.idx = mwdh_pkg::BIN_IDX_W'(bin_clamped);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            // samples outside the region are dropped here
            if (s1_move)
            begin
                s2_valid_reg <= (s1_op_reg != mwdh_pkg::OP_ADD) || s1_in_range_reg;
            end
            else if (q_push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= mwdh_pkg::op_t'(op);
            s1_diff_reg     <= diff_wide[31:0];
            s1_in_range_reg <= in_range;
            s1_mass_reg     <= mass;
            s1_sel_reg      <= bin_select;
            s1_sel_ok_reg   <= 32'(bin_select) < 32'(mwdh_pkg::BIN_DEPTH);
        end
        if (s1_move)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_bin_reg    <= prod[63:32];
            s2_mass_reg   <= s1_mass_reg;
            s2_sel_reg    <= s1_sel_reg;
            s2_sel_ok_reg <= s1_sel_ok_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mwdh_queue.sv -----
// short command queue between front end and back end
// register array with head and tail pointers
// depends on mwdh_pkg
`default_nettype none

module mwdh_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire mwdh_pkg::cmd_t wr_cmd,
    output logic                q_full,
    input  wire logic           rd_en,
    output mwdh_pkg::cmd_t      rd_cmd,
    output logic                q_empty
);

    mwdh_pkg::cmd_t                 entries_reg [mwdh_pkg::QUEUE_DEPTH];
    logic [mwdh_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mwdh_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mwdh_pkg::QPTR_W:0]      count_reg;
    logic [mwdh_pkg::QPTR_W:0]      count_next;

    assign q_full  = count_reg == (mwdh_pkg::QPTR_W + 1)'(mwdh_pkg::QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign rd_cmd  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mwdh_pkg::QPTR_W'(mwdh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mwdh_pkg::QPTR_W'(mwdh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mwdh_back.sv -----
// back end: bin store, read-modify-write of sums, frame count,
// density by shared multiplier and bit-serial divider, result register
// depends on mwdh_pkg
`default_nettype none

module mwdh_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    norm_scale,
    input  wire mwdh_pkg::cmd_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                clearing,
    output logic                empty,
    input  wire logic           pop,
    output logic [63:0]         density,
    output logic                no_frames,
    output logic [mwdh_pkg::SEL_W-1:0] read_bin
);

    logic [63:0] mem [mwdh_pkg::BIN_DEPTH];

    mwdh_pkg::back_state_t          state_reg;
    mwdh_pkg::back_state_t          state_next;
    mwdh_pkg::cmd_t                 cmd_reg;
    logic [mwdh_pkg::BIN_IDX_W-1:0] clr_cnt_reg;
    logic [mwdh_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [31:0]                    frame_count_reg;
    logic                           nof_reg;
    logic [63:0]                    rd_data_reg;
    logic [63:0]                    plo_reg;
    logic [63:0]                    phi_reg;
    logic [95:0]                    num_reg;
    logic [31:0]                    rem_reg;
    logic                           out_valid_reg;
    logic [63:0]                    out_density_reg;
    logic                           out_nof_reg;
    logic [mwdh_pkg::SEL_W-1:0]     out_sel_reg;

    logic                           rd_en;
    logic [mwdh_pkg::BIN_IDX_W-1:0] rd_addr;
    logic                           wr_en;
    logic [mwdh_pkg::BIN_IDX_W-1:0] wr_addr;
    logic [63:0]                    wr_data;
    logic                           res_load;
    logic                           out_free;
    logic [64:0]                    add_sum;
    logic [63:0]                    mul_in;
    logic [63:0]                    mul_prod;
    logic [32:0]                    trial;
    logic [32:0]                    trial_sub;
    logic                           q_bit;
    logic [63:0]                    density_calc;

    assign out_free  = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign density   = out_density_reg;
    assign no_frames = out_nof_reg;
    assign read_bin  = out_sel_reg;
    assign clearing  = state_reg == mwdh_pkg::ST_CLEAR;

    assign add_sum   = {1'b0, rd_data_reg} + {33'd0, cmd_reg.mass};
    assign mul_in    = (state_reg == mwdh_pkg::ST_MUL_LO) ? 64'(rd_data_reg[31:0])
                                                         : 64'(rd_data_reg[63:32]);
    assign mul_prod  = mul_in * 64'(norm_scale);
    assign trial     = {rem_reg, num_reg[95]};
    assign trial_sub = trial - {1'b0, frame_count_reg};
    assign q_bit     = trial >= {1'b0, frame_count_reg};
    // quotient is in Q.32, keep 16 fraction bits, saturate past 64 bits
    assign density_calc = (num_reg[95:80] != 16'd0) ? '1 : num_reg[79:16];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwdh_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == mwdh_pkg::BIN_IDX_W'(mwdh_pkg::BIN_DEPTH - 1))
                begin
                    state_next = mwdh_pkg::ST_IDLE;
                end
            end
            mwdh_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head.op)
                        mwdh_pkg::OP_ADD:   state_next = mwdh_pkg::ST_ADD_WR;
                        mwdh_pkg::OP_FRAME: state_next = mwdh_pkg::ST_IDLE;
                        mwdh_pkg::OP_READ:
                        begin
                            if (frame_count_reg == 32'd0 || !head.sel_ok)
                            begin
                                state_next = mwdh_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = mwdh_pkg::ST_MUL_LO;
                            end
                        end
                        mwdh_pkg::OP_CLEAR: state_next = mwdh_pkg::ST_CLEAR;
                        default:            state_next = mwdh_pkg::ST_IDLE;
                    endcase
                end
            end
            mwdh_pkg::ST_ADD_WR: state_next = mwdh_pkg::ST_IDLE;
            mwdh_pkg::ST_MUL_LO: state_next = mwdh_pkg::ST_MUL_HI;
            mwdh_pkg::ST_MUL_HI: state_next = mwdh_pkg::ST_SUM;
            mwdh_pkg::ST_SUM:    state_next = mwdh_pkg::ST_DIV;
            mwdh_pkg::ST_DIV:
            begin
                if (div_cnt_reg == mwdh_pkg::DIV_CNT_W'(mwdh_pkg::DIV_STEPS - 1))
                begin
                    state_next = mwdh_pkg::ST_DONE;
                end
            end
            mwdh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mwdh_pkg::ST_IDLE;
                end
            end
            default: state_next = mwdh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = head.idx;
        wr_en    = 1'b0;
        wr_addr  = cmd_reg.idx;
        wr_data  = add_sum[64] ? '1 : add_sum[63:0];
        res_load = 1'b0;
        unique case (state_reg)
            mwdh_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            mwdh_pkg::ST_IDLE:
            begin
                q_pop = !q_empty;
                rd_en = !q_empty && (head.op == mwdh_pkg::OP_ADD
                        || (head.op == mwdh_pkg::OP_READ && head.sel_ok));
            end
            mwdh_pkg::ST_ADD_WR:
            begin
                wr_en = 1'b1;
            end
            mwdh_pkg::ST_DONE:
            begin
                res_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mwdh_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            frame_count_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mwdh_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (state_reg == mwdh_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
            if (q_pop && head.op == mwdh_pkg::OP_FRAME && frame_count_reg != '1)
            begin
                frame_count_reg <= frame_count_reg + 32'd1;
            end
            else if (q_pop && head.op == mwdh_pkg::OP_CLEAR)
            begin
                frame_count_reg <= 32'd0;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= head;
            nof_reg <= frame_count_reg == 32'd0;
            num_reg <= '0;
        end
        unique case (state_reg)
            mwdh_pkg::ST_MUL_LO: plo_reg <= mul_prod;
            mwdh_pkg::ST_MUL_HI: phi_reg <= mul_prod;
            mwdh_pkg::ST_SUM:
            begin
                num_reg <= {phi_reg, 32'd0} + {32'd0, plo_reg};
                rem_reg <= 32'd0;
            end
            mwdh_pkg::ST_DIV:
            begin
                // one quotient bit per cycle, shifted in behind the dividend
                num_reg <= {num_reg[94:0], q_bit};
                rem_reg <= q_bit ? trial_sub[31:0] : trial[31:0];
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
        if (res_load)
        begin
            out_density_reg <= density_calc;
            out_nof_reg     <= nof_reg;
            out_sel_reg     <= cmd_reg.sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mass_weighted_density_histogram_unit.sv -----
// a sample passes front stages s1 and s2, the queue, the bin store read and the
// write in ST_ADD_WR; a read of a valid bin with frames counted adds two
// multiplier passes, a sum step and the 96-step divider; the back end takes a
// command only when done with the last, while requests still fill the queue
// reset: config registers to defaults, frame count zero, then a clearing pass over
// all 512 bin entries with full held high; a clear request does all but config
`default_nettype none

module mass_weighted_density_histogram_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          op,
    input  wire logic signed [31:0]  position,
    input  wire logic [31:0]         mass,
    input  wire logic [8:0]          bin_select,
    output logic                     empty,
    input  wire logic                pop,
    output logic [63:0]              density,
    output logic                     no_frames,
    output logic [8:0]               read_bin,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [mwdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]         cfg_data
);

    mwdh_pkg::cfg_t cfg_reg;
    mwdh_pkg::cmd_t q_wr_cmd;
    mwdh_pkg::cmd_t q_head;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    logic           clearing;
    logic           cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_bound   <= mwdh_pkg::RST_LOW_BOUND;
            cfg_reg.up_bound    <= mwdh_pkg::RST_UP_BOUND;
            cfg_reg.inv_width   <= mwdh_pkg::RST_INV_WIDTH;
            cfg_reg.bins_in_use <= mwdh_pkg::RST_BINS;
            cfg_reg.norm_scale  <= mwdh_pkg::RST_NORM_SCALE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                mwdh_pkg::REG_LOW_BOUND:  cfg_reg.low_bound   <= cfg_data;
                mwdh_pkg::REG_UP_BOUND:   cfg_reg.up_bound    <= cfg_data;
                mwdh_pkg::REG_INV_WIDTH:  cfg_reg.inv_width   <= cfg_data;
                mwdh_pkg::REG_BINS:       cfg_reg.bins_in_use <= cfg_data[9:0];
                mwdh_pkg::REG_NORM_SCALE: cfg_reg.norm_scale  <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    mwdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .hold       (clearing),
        .push       (push),
        .full       (full),
        .op         (op),
        .position   (position),
        .mass       (mass),
        .bin_select (bin_select),
        .q_push     (q_push),
        .q_cmd      (q_wr_cmd),
        .q_full     (q_full)
    );

    mwdh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_head),
        .q_empty (q_empty)
    );

    mwdh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .norm_scale (cfg_reg.norm_scale),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .density    (density),
        .no_frames  (no_frames),
        .read_bin   (read_bin)
    );

endmodule

`default_nettype wire
